@@ rtl/core/ups_pkg.sv @@
// shared constants and types for the ups status poll parser
package ups_pkg;

	// frame buffer and word limits
	localparam int BUFFER_BYTES = 150;
	localparam int MAX_WORDS    = 8;

	// expected shape of a good status reply
	localparam logic [3:0] GOOD_WORDS = 4'd8;
	localparam logic [7:0] GOOD_LEN   = 8'd8;

	// ascii codes the parser reacts to
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// input action codes
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_BYTE = 1'b1;

	// configuration register indexes
	localparam logic [7:0] REG_TIMEOUT = 8'd0;
	localparam logic [7:0] REG_PAUSE   = 8'd1;

	// link status codes
	localparam logic [1:0] LINK_UNKNOWN = 2'd0;
	localparam logic [1:0] LINK_NONE    = 2'd1;
	localparam logic [1:0] LINK_OK      = 2'd2;

	// reset values of the configuration registers
	localparam logic [23:0] TIMEOUT_RESET = 24'd4000;
	localparam logic [23:0] PAUSE_RESET   = 24'd3000;

	// one result beat
	typedef struct packed {
		logic       send_request;
		logic [1:0] link_status;
		logic       frame_done;
		logic       frame_ok;
		logic [3:0] words_seen;
		logic [7:0] final_word_length;
	} res_t;

endpackage

@@ rtl/core/ups_status_poll_parser.sv @@
// ups status poll parser: poll sequencer, reply frame parser and result buffer
//
// Usage: each input beat (in_valid, not in_stall) is a time tick (action 0) or
// one received uart byte (action 1, rx_byte). Every input beat produces exactly
// one result beat on the output channel (out_valid, out_stall).
// A tick in the home phase raises send_request and starts the wait phase; bytes
// received while waiting are parsed, a CR ends the frame and reports its word
// count and last word length. A good frame sets link_status to ok, a wait past
// response_timeout_ticks sets no link; both then pause until more than pause_ticks ticks have passed.
// The result of a beat is registered and on the outputs the cycle after
// acceptance unless an earlier result is still held by out_stall.
// Throughput: one beat per cycle while in_stall is low; the whole state update is one pass of
// counter and compare logic between the input and the result register.
// A two-entry result buffer (output register plus skid register) lets a beat
// be accepted while a result waits; in_stall rises only when both are full.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// write only while the block is idle. Indexes beyond 1 are ignored.
// Reset (arst_n low): home phase, parser idle, link unknown, registers back to
// 4000 and 3000 ticks, result buffer empty.
module ups_status_poll_parser (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  rx_byte,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        send_request,
	output logic [1:0]  link_status,
	output logic        frame_done,
	output logic        frame_ok,
	output logic [3:0]  words_seen,
	output logic [7:0]  final_word_length,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	typedef enum logic [1:0] {
		PH_HOME  = 2'd0,
		PH_WAIT  = 2'd1,
		PH_PAUSE = 2'd2
	} phase_t;

	phase_t         phase_q, phase_d;
	logic [23:0]    elapsed_q, elapsed_d;
	logic           in_frame_q, in_frame_d;
	logic [7:0]     char_pos_q, char_pos_d;
	logic [3:0]     word_cnt_q, word_cnt_d;
	logic [7:0]     word_len_q, word_len_d;
	logic [1:0]     link_q, link_d;
	logic [23:0]    timeout_q, pause_q;
	logic [23:0]    limit;
	ups_pkg::res_t  res;
	ups_pkg::res_t  out_q, skid_q;
	logic           out_valid_q, skid_valid_q;
	logic           in_acc, out_take;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign in_acc    = in_valid && !skid_valid_q;
	assign out_take  = out_valid_q && !out_stall;

	assign limit = (phase_q == PH_WAIT) ? timeout_q : pause_q;

	// next state and result of one input beat
	always_comb begin
		phase_d    = phase_q;
		elapsed_d  = elapsed_q;
		in_frame_d = in_frame_q;
		char_pos_d = char_pos_q;
		word_cnt_d = word_cnt_q;
		word_len_d = word_len_q;
		link_d     = link_q;
		res        = '0;
		if (action == ups_pkg::ACT_TICK) begin
			unique case (phase_q) inside
				PH_WAIT, PH_PAUSE: begin
					if (elapsed_q >= limit) begin
						elapsed_d = '0;
						if (phase_q == PH_WAIT) begin
							link_d  = ups_pkg::LINK_NONE;
							phase_d = PH_PAUSE;
						end else begin
							phase_d = PH_HOME;
						end
					end else begin
						elapsed_d = elapsed_q + 24'd1;
					end
				end
				default: begin
					res.send_request = 1'b1;
					elapsed_d        = '0;
					phase_d          = PH_WAIT;
				end
			endcase
		end else if (phase_q == PH_WAIT) begin
			// frame parser
			if (!in_frame_q) begin
				if (rx_byte == ups_pkg::CH_OPEN) begin
					char_pos_d = '0;
					word_cnt_d = '0;
					word_len_d = '0;
					in_frame_d = 1'b1;
				end
			end else if (rx_byte == ups_pkg::CH_CR) begin
				res.frame_done        = 1'b1;
				res.words_seen        = word_cnt_q + 4'd1;
				res.final_word_length = word_len_q;
				in_frame_d            = 1'b0;
				if (res.words_seen == ups_pkg::GOOD_WORDS &&
				    word_len_q == ups_pkg::GOOD_LEN) begin
					res.frame_ok = 1'b1;
					link_d       = ups_pkg::LINK_OK;
				end
				elapsed_d = '0;
				phase_d   = PH_PAUSE;
			end else if (char_pos_q >= 8'(ups_pkg::BUFFER_BYTES - 1)) begin
				// buffer full: abort frame
				in_frame_d = 1'b0;
			end else begin
				if (rx_byte == ups_pkg::CH_SPACE) begin
					if (({1'b0, word_cnt_q} + 5'd1) < 5'(ups_pkg::MAX_WORDS)) begin
						word_cnt_d = word_cnt_q + 4'd1;
						word_len_d = '0;
					end else begin
						// too many words: abort frame
						in_frame_d = 1'b0;
					end
				end else begin
					word_len_d = word_len_q + 8'd1;
				end
				char_pos_d = char_pos_q + 8'd1;
			end
		end
		res.link_status = link_d;
	end

	// state, configuration and result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HOME;
			elapsed_q    <= '0;
			in_frame_q   <= 1'b0;
			char_pos_q   <= '0;
			word_cnt_q   <= '0;
			word_len_q   <= '0;
			link_q       <= ups_pkg::LINK_UNKNOWN;
			timeout_q    <= ups_pkg::TIMEOUT_RESET;
			pause_q      <= ups_pkg::PAUSE_RESET;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					ups_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
					ups_pkg::REG_PAUSE:   pause_q   <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				phase_q    <= phase_d;
				elapsed_q  <= elapsed_d;
				in_frame_q <= in_frame_d;
				char_pos_q <= char_pos_d;
				word_cnt_q <= word_cnt_d;
				word_len_q <= word_len_d;
				link_q     <= link_d;
			end
			// result beat into output or skid register
			if (out_take) begin
				if (skid_valid_q) begin
					out_q        <= skid_q;
					skid_valid_q <= 1'b0;
				end else if (in_acc) begin
					out_q <= res;
				end else begin
					out_valid_q <= 1'b0;
				end
			end else if (in_acc) begin
				if (out_valid_q) begin
					skid_q       <= res;
					skid_valid_q <= 1'b1;
				end else begin
					out_q       <= res;
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign send_request      = out_q.send_request;
	assign link_status       = out_q.link_status;
	assign frame_done        = out_q.frame_done;
	assign frame_ok          = out_q.frame_ok;
	assign words_seen        = out_q.words_seen;
	assign final_word_length = out_q.final_word_length;

endmodule

@@ rtl/core/ups_checker.sv @@
// port level checks for the ups status poll parser, bound to the top level
module ups_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        send_request,
	input logic [1:0]  link_status,
	input logic        frame_done,
	input logic        frame_ok,
	input logic [3:0]  words_seen,
	input logic [7:0]  final_word_length
);

	// a good frame always reports link ok on the same beat
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_ok |-> frame_done && link_status == ups_pkg::LINK_OK)
		else $error("frame_ok without frame_done or link ok");

	// a poll request and a frame end never share a beat
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_request |-> !frame_done)
		else $error("send_request together with frame_done");

	// frame fields are zero unless a frame ended, word count in range otherwise
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_done ? (words_seen != 4'd0 &&
			words_seen <= 4'(ups_pkg::MAX_WORDS))
			: (words_seen == 4'd0 && final_word_length == 8'd0)))
		else $error("frame fields inconsistent with frame_done");

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(link_status) &&
			$stable(frame_done) && $stable(send_request))
		else $error("stalled result beat changed");

endmodule

bind ups_status_poll_parser ups_checker u_ups_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.send_request      (send_request),
	.link_status       (link_status),
	.frame_done        (frame_done),
	.frame_ok          (frame_ok),
	.words_seen        (words_seen),
	.final_word_length (final_word_length)
);
